/* sv/ssel_pkg.sv */
// Package for the save-slot selector: field widths, the slot item type and the
// wrap-aware sequence compare. No dependencies.
package ssel_pkg;

  localparam int unsigned SEQ_W         = 32;
  localparam int unsigned SLOT_OUT_W    = 3;
  localparam int unsigned MAX_SLOTS_DEF = 8;

  typedef struct packed {
    logic             slot_valid;
    logic [SEQ_W-1:0] slot_sequence;
    logic             last_slot;
  } slot_item_t;

  // True when a is strictly newer than b under 32-bit wrapping order.
  function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return (diff != '0) && !diff[SEQ_W-1];
  endfunction

endpackage

/* sv/ssel_in_stage.sv */
// Input register of the save-slot selector: captures one slot item per cycle
// unless stalled and holds it until the scan core takes it. Depends on ssel_pkg.
module ssel_in_stage
  import ssel_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  slot_item_t item_i,
  output logic       item_valid_o,
  output slot_item_t item_o,
  input  logic       take_i
);

  logic       full_q, full_d;
  slot_item_t item_q;
  logic       accept;

  // The register frees up in the same cycle that the core takes its item.
  assign in_stall_o = full_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    full_d = full_q;
    if (accept) begin
      full_d = 1'b1;
    end else if (take_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = full_q;
  assign item_o       = item_q;

endmodule

/* sv/ssel_scan_core.sv */
// Running scan state and result register of the save-slot selector. One slot
// item is folded into the state per cycle unless stalled. Depends on ssel_pkg.
module ssel_scan_core
  import ssel_pkg::*;
#(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  slot_item_t            item_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  newest_found_o,
  output logic [SLOT_OUT_W-1:0] newest_slot_o,
  output logic [SLOT_OUT_W-1:0] write_slot_o
);

  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned PosW = $clog2(MaxSlots + 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             have_newest_q, have_newest_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [SEQ_W-1:0] best_seq_q, best_seq_d;
  logic             have_free_q, have_free_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [IdxW-1:0]  stale_idx_q, stale_idx_d;
  logic [SEQ_W-1:0] stale_seq_q, stale_seq_d;

  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  logic [SLOT_OUT_W-1:0] newest_q, write_q;

  logic                  in_range;
  logic [IdxW-1:0]       idx;
  logic [IdxW+SLOT_OUT_W-1:0] newest_wide, write_wide;

  // A last item may only move on when the result register is free.
  assign take_o = item_valid_i && (!item_i.last_slot || !out_valid_q || !out_stall_i);

  assign in_range = pos_q < PosW'(MaxSlots);
  assign idx      = pos_q[IdxW-1:0];

  always_comb begin
    pos_d         = pos_q;
    have_newest_d = have_newest_q;
    best_idx_d    = best_idx_q;
    best_seq_d    = best_seq_q;
    have_free_d   = have_free_q;
    free_idx_d    = free_idx_q;
    stale_idx_d   = stale_idx_q;
    stale_seq_d   = stale_seq_q;
    if (in_range) begin
      if (item_i.slot_valid) begin
        if (!have_newest_q || seq_newer(item_i.slot_sequence, best_seq_q)) begin
          have_newest_d = 1'b1;
          best_idx_d    = idx;
          best_seq_d    = item_i.slot_sequence;
        end
      end else if (!have_free_q) begin
        have_free_d = 1'b1;
        free_idx_d  = idx;
      end
      // The oldest pick tracks every slot, valid or not; ties stay earlier.
      if (pos_q == '0 || seq_newer(stale_seq_q, item_i.slot_sequence)) begin
        stale_idx_d = idx;
        stale_seq_d = item_i.slot_sequence;
      end
      pos_d = pos_q + PosW'(1);
    end
  end

  // Result fields are computed from the updated state and masked to 3 bits.
  assign newest_wide = {{SLOT_OUT_W{1'b0}}, (have_newest_d ? best_idx_d : '0)};
  assign write_wide  = {{SLOT_OUT_W{1'b0}}, (have_free_d ? free_idx_d : stale_idx_d)};

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o && item_i.last_slot) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      have_newest_q <= 1'b0;
      best_idx_q    <= '0;
      best_seq_q    <= '0;
      have_free_q   <= 1'b0;
      free_idx_q    <= '0;
      stale_idx_q   <= '0;
      stale_seq_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        if (item_i.last_slot) begin
          pos_q         <= '0;
          have_newest_q <= 1'b0;
          best_idx_q    <= '0;
          best_seq_q    <= '0;
          have_free_q   <= 1'b0;
          free_idx_q    <= '0;
          stale_idx_q   <= '0;
          stale_seq_q   <= '0;
        end else begin
          pos_q         <= pos_d;
          have_newest_q <= have_newest_d;
          best_idx_q    <= best_idx_d;
          best_seq_q    <= best_seq_d;
          have_free_q   <= have_free_d;
          free_idx_q    <= free_idx_d;
          stale_idx_q   <= stale_idx_d;
          stale_seq_q   <= stale_seq_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last_slot) begin
      found_q  <= have_newest_d;
      newest_q <= newest_wide[SLOT_OUT_W-1:0];
      write_q  <= write_wide[SLOT_OUT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign newest_found_o = found_q;
  assign newest_slot_o  = newest_q;
  assign write_slot_o   = write_q;

endmodule

/* sv/save_slot_selector_unit.sv */
// Top level of the save-slot selector: input register followed by the scan
// core with its result register. Depends on ssel_pkg, ssel_in_stage, ssel_scan_core.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid_i/in_stall_o | slot_valid_i, slot_sequence_i, last_slot_i
//   out     | out_valid_o/out_stall_i | newest_found_o, newest_slot_o, write_slot_o
//
// One slot item is accepted per cycle while in_stall_o is low. The last item of a
// scan is held in the input register, then taken by one compare-and-update pass
// of the scan core that loads its report into the result register. Reset clears
// the scan state and both valid flags. A stalled result holds the core only when
// the next item held in the input register is itself a last item.
module save_slot_selector_unit
  import ssel_pkg::*;
#(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  slot_valid_i,
  input  logic [SEQ_W-1:0]      slot_sequence_i,
  input  logic                  last_slot_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  newest_found_o,
  output logic [SLOT_OUT_W-1:0] newest_slot_o,
  output logic [SLOT_OUT_W-1:0] write_slot_o
);

  slot_item_t item_in, item_reg;
  logic       item_valid;
  logic       take;

  assign item_in.slot_valid    = slot_valid_i;
  assign item_in.slot_sequence = slot_sequence_i;
  assign item_in.last_slot     = last_slot_i;

  ssel_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_o       (item_reg),
    .take_i       (take)
  );

  ssel_scan_core #(
    .MaxSlots (MaxSlots)
  ) u_scan_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item_reg),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .newest_found_o (newest_found_o),
    .newest_slot_o  (newest_slot_o),
    .write_slot_o   (write_slot_o)
  );

endmodule
